### rtl/cpuutil_pkg.sv
// shared types, constants and saturating helpers for the cpu utilization block
package cpuutil_pkg;

	localparam int CORE_SLOTS = 64;
	localparam int CORE_W    = 6;
	localparam int CNT_W     = 64;
	localparam int N_CNT     = 10;
	localparam int PCT_W     = 15;
	localparam int DIV_STEPS = 15;
	// busy * 100 fits in 71 bits
	localparam int PROD_W    = CNT_W + 7;

	localparam logic [PCT_W-1:0] FULL_SCALE = PCT_W'(25600);

	// per-core counter slots, also the order of the deltas on the output
	localparam int CNT_USER    = 0;
	localparam int CNT_NICE    = 1;
	localparam int CNT_SYSTEM  = 2;
	localparam int CNT_SYSALL  = 3;
	localparam int CNT_IDLE    = 4;
	localparam int CNT_IOWAIT  = 5;
	localparam int CNT_IRQ     = 6;
	localparam int CNT_SOFTIRQ = 7;
	localparam int CNT_STEAL   = 8;
	localparam int CNT_TOTAL   = 9;

	// input sample slots in s_tdata
	localparam int IN_USER    = 0;
	localparam int IN_NICE    = 1;
	localparam int IN_SYSTEM  = 2;
	localparam int IN_IDLE    = 3;
	localparam int IN_IOWAIT  = 4;
	localparam int IN_IRQ     = 5;
	localparam int IN_SOFTIRQ = 6;
	localparam int IN_STEAL   = 7;
	localparam int IN_GUEST   = 8;
	localparam int IN_GNICE   = 9;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [PCT_W-1:0]            held;
		logic [N_CNT-1:0][CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] quot;
	} div_res_t;

	function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	function automatic cnt_t sat_sub(input cnt_t a, input cnt_t b);
		return (a > b) ? (a - b) : '0;
	endfunction

endpackage

### rtl/cpuutil_div.sv
// iterative busy share unit: floor(busy*25600/total), clamped to full scale
module cpuutil_div import cpuutil_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  cnt_t     busy,
	input  cnt_t     total,
	output div_res_t res
);

	localparam int DIVD_W = PROD_W + 8;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_MUL1 = 2'd1;
	localparam logic [1:0] DV_MUL2 = 2'd2;
	localparam logic [1:0] DV_LOOP = 2'd3;

	logic [1:0]           st_q;
	logic [STEP_W-1:0]    step_q;
	logic                 done_q;
	cnt_t                 b_q;
	cnt_t                 t_q;
	logic [PROD_W-1:0]    prod_q;
	cnt_t                 rem_q;
	logic [DIV_STEPS-1:0] sh_q;
	logic [PCT_W-1:0]     quot_q;

	logic [PROD_W-1:0] prod_next;
	logic [DIVD_W-1:0] divd;
	logic [CNT_W:0]    trial;
	logic              ge;

	// busy * 100 = (b << 6) + (b << 5) + (b << 2); the * 256 is a shift
	assign prod_next = prod_q + (PROD_W'(b_q) << 2);
	assign divd      = {prod_next, 8'b0};
	assign trial     = {rem_q, sh_q[DIV_STEPS-1]};
	assign ge        = trial >= {1'b0, t_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				DV_IDLE: begin
					if (start) begin
						if (busy >= total) begin
							done_q <= 1'b1;
						end else begin
							st_q <= DV_MUL1;
						end
					end
				end
				DV_MUL1: st_q <= DV_MUL2;
				DV_MUL2: begin
					st_q   <= DV_LOOP;
					step_q <= '0;
				end
				DV_LOOP: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						st_q   <= DV_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: begin
				if (start) begin
					b_q    <= busy;
					t_q    <= total;
					quot_q <= FULL_SCALE;
				end
			end
			DV_MUL1: prod_q <= (PROD_W'(b_q) << 6) + (PROD_W'(b_q) << 5);
			DV_MUL2: begin
				// quotient fits in 15 bits, so the top part is already below total
				rem_q  <= divd[DIVD_W-1:DIV_STEPS];
				sh_q   <= divd[DIV_STEPS-1:0];
				quot_q <= '0;
			end
			DV_LOOP: begin
				rem_q  <= ge ? CNT_W'(trial - {1'b0, t_q}) : trial[CNT_W-1:0];
				sh_q   <= sh_q << 1;
				quot_q <= {quot_q[PCT_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule

### rtl/cpu_core_utilization_calc_core.sv
// per-core cpu utilization from cumulative tick counters, state kept in one counter memory
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | ten 64-bit tick counters, 640 bits        | core_index (6)
//  m_      | out | ten 64-bit deltas, busy_percent, pad bit | percent_fresh (1)
//
// path from accept to result when the share is divided out: the sum states, delta,
// the busy sums, divider start, the divider's multiply states, the 15-step quotient
// loop, write-back and output load; busy reaching the total skips the multiply and the
// loop, a zero total delta skips the divider; the next sample waits for the output load.
// reset clears the per-core valid bits at once, an unwritten core reads as zero.
// a result waits in the output register while the next sample runs; a second one stalls.
module cpu_core_utilization_calc_core import cpuutil_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// user, nice, system, idle, iowait, irq, softirq, steal, guest, guest_nice
	input  logic [639:0] s_tdata,
	// core_index
	input  logic [5:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// user, nice, system, system_all, idle, iowait, irq, softirq, steal,
	// total deltas, busy_percent [654:640], zero pad [655]
	output logic [655:0] m_tdata,
	// percent_fresh
	output logic [0:0]   m_tuser
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SUM1  = 4'd1;
	localparam logic [3:0] ST_SUM2  = 4'd2;
	localparam logic [3:0] ST_SUM3  = 4'd3;
	localparam logic [3:0] ST_SUM4  = 4'd4;
	localparam logic [3:0] ST_DELTA = 4'd5;
	localparam logic [3:0] ST_BUSY1 = 4'd6;
	localparam logic [3:0] ST_BUSY2 = 4'd7;
	localparam logic [3:0] ST_DIVGO = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_WB    = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]                  state_q;
	logic [N_CNT-1:0][CNT_W-1:0] in_q;
	logic [CORE_W-1:0]           core_q;
	logic                        core_ok_q;
	logic [CORE_SLOTS-1:0]       vld_q;
	logic                        rd_vld_q;
	entry_t                      rd_q;
	entry_t                      mem_q [CORE_SLOTS];
	logic [N_CNT-1:0][CNT_W-1:0] cur_q;
	logic [N_CNT-1:0][CNT_W-1:0] d_q;
	cnt_t                        p0_q, p1_q, p2_q;
	logic [PCT_W-1:0]            held_q;
	logic [PCT_W-1:0]            pct_q;
	logic                        fresh_q;
	logic                        m_tvalid_q;
	logic [655:0]                m_tdata_q;
	logic                        m_tuser_q;

	logic     accept;
	logic     core_ok;
	logic     mem_we;
	logic     out_free;
	logic     out_load;
	logic     div_start;
	entry_t   old_e;
	entry_t   wr_e;
	div_res_t div_res;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign core_ok   = {26'b0, s_tuser} < 32'(CORE_SLOTS);
	assign mem_we    = (state_q == ST_WB);
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = (state_q == ST_OUT) && out_free;
	assign div_start = (state_q == ST_DIVGO);
	assign old_e     = rd_vld_q ? rd_q : '0;
	assign wr_e.held = pct_q;
	assign wr_e.cnt  = cur_q;

	cpuutil_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.busy   (p0_q),
		.total  (d_q[CNT_TOTAL]),
		.res    (div_res)
	);

	// counter memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[core_q] <= wr_e;
		end
		if (accept) begin
			rd_q <= mem_q[s_tuser];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[core_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= core_ok ? ST_SUM1 : ST_OUT;
					end
				end
				ST_SUM1:  state_q <= ST_SUM2;
				ST_SUM2:  state_q <= ST_SUM3;
				ST_SUM3:  state_q <= ST_SUM4;
				ST_SUM4:  state_q <= ST_DELTA;
				ST_DELTA: state_q <= ST_BUSY1;
				ST_BUSY1: state_q <= ST_BUSY2;
				ST_BUSY2: state_q <= (d_q[CNT_TOTAL] == '0) ? ST_WB : ST_DIVGO;
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					in_q      <= s_tdata;
					core_q    <= s_tuser;
					core_ok_q <= core_ok;
					rd_vld_q  <= vld_q[s_tuser];
				end
			end
			ST_SUM1: begin
				cur_q[CNT_USER]    <= sat_sub(in_q[IN_USER], in_q[IN_GUEST]);
				cur_q[CNT_NICE]    <= sat_sub(in_q[IN_NICE], in_q[IN_GNICE]);
				cur_q[CNT_SYSTEM]  <= in_q[IN_SYSTEM];
				cur_q[CNT_IDLE]    <= in_q[IN_IDLE];
				cur_q[CNT_IOWAIT]  <= in_q[IN_IOWAIT];
				cur_q[CNT_IRQ]     <= in_q[IN_IRQ];
				cur_q[CNT_SOFTIRQ] <= in_q[IN_SOFTIRQ];
				cur_q[CNT_STEAL]   <= in_q[IN_STEAL];
				p0_q <= sat_add(in_q[IN_IDLE], in_q[IN_IOWAIT]);
				p1_q <= sat_add(in_q[IN_SYSTEM], in_q[IN_IRQ]);
				p2_q <= sat_add(in_q[IN_GUEST], in_q[IN_GNICE]);
			end
			ST_SUM2: begin
				// saturating sums of unsigned terms may be regrouped freely
				cur_q[CNT_SYSALL] <= sat_add(p1_q, in_q[IN_SOFTIRQ]);
				p1_q <= sat_add(cur_q[CNT_USER], cur_q[CNT_NICE]);
				p2_q <= sat_add(in_q[IN_STEAL], p2_q);
			end
			ST_SUM3: begin
				p0_q <= sat_add(p0_q, p2_q);
				p1_q <= sat_add(p1_q, cur_q[CNT_SYSALL]);
			end
			ST_SUM4: cur_q[CNT_TOTAL] <= sat_add(p0_q, p1_q);
			ST_DELTA: begin
				for (int k = 0; k < N_CNT; k++) begin
					d_q[k] <= sat_sub(cur_q[k], old_e.cnt[k]);
				end
				held_q <= old_e.held;
			end
			ST_BUSY1: begin
				p0_q <= sat_add(d_q[CNT_USER], d_q[CNT_NICE]);
				p1_q <= sat_add(d_q[CNT_SYSALL], d_q[CNT_STEAL]);
			end
			ST_BUSY2: begin
				p0_q    <= sat_add(p0_q, p1_q);
				pct_q   <= held_q;
				fresh_q <= 1'b0;
			end
			ST_DIV: begin
				if (div_res.done) begin
					pct_q   <= div_res.quot;
					fresh_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output register: an ignored core index gives an all-zero result
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (core_ok_q) begin
				m_tdata_q <= {1'b0, pct_q, d_q};
				m_tuser_q <= fresh_q;
			end else begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	a_wb_valid_core: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> core_ok_q)
		else $error("memory write for an ignored core index");

	a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("pending result overwritten");

	a_pct_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[654:640] <= FULL_SCALE))
		else $error("busy share beyond full scale");

endmodule

### tb/tb_cpu_core_utilization_calc_core.sv
// self-checking testbench for the per-core cpu utilization block
module tb_cpu_core_utilization_calc_core;
	import cpuutil_pkg::*;

	localparam int IDLE_LIMIT  = 5000;
	localparam int MAX_REPORTS = 40;

	typedef logic [N_CNT-1:0][CNT_W-1:0] sample_t;

	typedef struct packed {
		logic [N_CNT-1:0][CNT_W-1:0] delta;
		logic [PCT_W-1:0]            pct;
		logic                        fresh;
	} usage_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [639:0] s_tdata;
	logic [5:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [655:0] m_tdata;
	logic [0:0]   m_tuser;

	// predictor state, one entry per core
	sample_t          core_cnt [CORE_SLOTS];
	logic [PCT_W-1:0] core_pct [CORE_SLOTS];
	// last counters sent to each core, the base for monotonic streams
	sample_t          stream_cnt [CORE_SLOTS];

	usage_t usage_q [$];
	usage_t exp_usage;
	usage_t got_usage;

	int errors;
	int samples_sent;
	int results_seen;
	int held_seen;
	int full_seen;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;

	cpu_core_utilization_calc_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic cnt_t add_clamp(input cnt_t a, input cnt_t b);
		cnt_t s;
		s = a + b;
		return (s < a) ? {CNT_W{1'b1}} : s;
	endfunction

	function automatic cnt_t sub_floor(input cnt_t a, input cnt_t b);
		if (a > b)
			return a - b;
		return '0;
	endfunction

	function automatic cnt_t rand_cnt();
		return {$urandom, $urandom};
	endfunction

	// increment of mixed magnitude for monotonic counter streams
	function automatic cnt_t tick_step();
		case ($urandom_range(3))
			0: return '0;
			1: return cnt_t'($urandom_range(100));
			2: return cnt_t'($urandom_range(1000000));
			default: return cnt_t'($urandom);
		endcase
	endfunction

	function automatic sample_t mk_sample(input cnt_t u, input cnt_t n, input cnt_t s,
			input cnt_t i, input cnt_t io, input cnt_t irq, input cnt_t sirq,
			input cnt_t st, input cnt_t g, input cnt_t gn);
		sample_t smp;
		smp[IN_USER]    = u;
		smp[IN_NICE]    = n;
		smp[IN_SYSTEM]  = s;
		smp[IN_IDLE]    = i;
		smp[IN_IOWAIT]  = io;
		smp[IN_IRQ]     = irq;
		smp[IN_SOFTIRQ] = sirq;
		smp[IN_STEAL]   = st;
		smp[IN_GUEST]   = g;
		smp[IN_GNICE]   = gn;
		return smp;
	endfunction

	// deltas and busy share of one sample, updates the per-core state
	function automatic usage_t predict_usage(input logic [CORE_W-1:0] core,
			input sample_t smp);
		cnt_t         u, n, sys_all, idle_all, virt, tot, busy;
		logic [127:0] prod, quo;
		sample_t      now_cnt;
		usage_t       r;
		int           j;
		u        = sub_floor(smp[IN_USER], smp[IN_GUEST]);
		n        = sub_floor(smp[IN_NICE], smp[IN_GNICE]);
		idle_all = add_clamp(smp[IN_IDLE], smp[IN_IOWAIT]);
		sys_all  = add_clamp(add_clamp(smp[IN_SYSTEM], smp[IN_IRQ]), smp[IN_SOFTIRQ]);
		virt     = add_clamp(smp[IN_GUEST], smp[IN_GNICE]);
		tot      = add_clamp(add_clamp(add_clamp(u, n), add_clamp(sys_all, idle_all)),
			add_clamp(smp[IN_STEAL], virt));
		now_cnt[CNT_USER]    = u;
		now_cnt[CNT_NICE]    = n;
		now_cnt[CNT_SYSTEM]  = smp[IN_SYSTEM];
		now_cnt[CNT_SYSALL]  = sys_all;
		now_cnt[CNT_IDLE]    = smp[IN_IDLE];
		now_cnt[CNT_IOWAIT]  = smp[IN_IOWAIT];
		now_cnt[CNT_IRQ]     = smp[IN_IRQ];
		now_cnt[CNT_SOFTIRQ] = smp[IN_SOFTIRQ];
		now_cnt[CNT_STEAL]   = smp[IN_STEAL];
		now_cnt[CNT_TOTAL]   = tot;
		for (j = 0; j < N_CNT; j++)
			r.delta[j] = sub_floor(now_cnt[j], core_cnt[core][j]);
		core_cnt[core] = now_cnt;
		if (r.delta[CNT_TOTAL] == '0) begin
			r.pct   = core_pct[core];
			r.fresh = 1'b0;
		end else begin
			busy = add_clamp(add_clamp(r.delta[CNT_USER], r.delta[CNT_NICE]),
				add_clamp(r.delta[CNT_SYSALL], r.delta[CNT_STEAL]));
			prod = {64'd0, busy} * 128'(FULL_SCALE);
			quo  = prod / {64'd0, r.delta[CNT_TOTAL]};
			r.pct = (quo > 128'(FULL_SCALE)) ? FULL_SCALE : quo[PCT_W-1:0];
			core_pct[core] = r.pct;
			r.fresh = 1'b1;
		end
		return r;
	endfunction

	function automatic string delta_name(input int idx);
		case (idx)
			CNT_USER:    return "user_delta";
			CNT_NICE:    return "nice_delta";
			CNT_SYSTEM:  return "system_delta";
			CNT_SYSALL:  return "system_all_delta";
			CNT_IDLE:    return "idle_delta";
			CNT_IOWAIT:  return "iowait_delta";
			CNT_IRQ:     return "irq_delta";
			CNT_SOFTIRQ: return "softirq_delta";
			CNT_STEAL:   return "steal_delta";
			default:     return "total_delta";
		endcase
	endfunction

	// one sample transaction; valid stays high into the next call when it does not idle
	task automatic send_sample(input logic [CORE_W-1:0] core, input sample_t smp);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= core;
		@(posedge clk);
		while (!(s_tvalid && s_tready))
			@(posedge clk);
		usage_q.insert(usage_q.size(), predict_usage(core, smp));
		stream_cnt[core] = smp;
		samples_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (usage_q.size() != 0)
			@(posedge clk);
	endtask

	// first samples on fresh cores, held percentage, zero and full busy share
	task automatic test_first_samples();
		send_sample(6'd0, '0);
		send_sample(6'd0, mk_sample(1000, 50, 200, 700, 50, 10, 5, 0, 100, 10));
		send_sample(6'd0, mk_sample(1000, 50, 200, 700, 50, 10, 5, 0, 100, 10));
		send_sample(6'd63, mk_sample(0, 0, 0, 5000, 0, 0, 0, 0, 0, 0));
		send_sample(6'd63, mk_sample(3000, 0, 0, 5000, 0, 0, 0, 0, 0, 0));
		send_sample(6'd63, mk_sample(3001, 0, 0, 5002, 0, 0, 0, 0, 0, 0));
		send_sample(6'd63, mk_sample(3002, 0, 0, 5002, 0, 0, 0, 77, 0, 0));
	endtask

	// all-ones counters, guest above user, sum overflow
	task automatic test_saturation();
		send_sample(6'd5, {N_CNT{{CNT_W{1'b1}}}});
		send_sample(6'd5, {N_CNT{{CNT_W{1'b1}}}});
		send_sample(6'd6, mk_sample(10, 0, 0, 0, 0, 0, 0, 0, 50, 7));
		send_sample(6'd6, {N_CNT{64'h8000_0000_0000_0000}});
		send_sample(6'd6, mk_sample(64'hFFFF_FFFF_FFFF_FFFE, 64'h1, 64'h2, 64'h3,
			64'hFFFF_FFFF_0000_0000, 64'h5, 64'h6, 64'h7, 64'h0, 64'h0));
		send_sample(6'd6, '0);
	endtask

	// counters going backwards, busy above total, fractional shares
	task automatic test_backwards_and_clamp();
		send_sample(6'd7, mk_sample(100, 0, 0, 1000000, 0, 0, 0, 0, 0, 0));
		send_sample(6'd7, mk_sample(5100, 0, 0, 999000, 0, 0, 0, 0, 0, 0));
		send_sample(6'd7, mk_sample(5100, 0, 0, 999000, 1, 0, 0, 0, 0, 0));
		send_sample(6'd7, mk_sample(5101, 0, 0, 999002, 1, 0, 0, 0, 0, 0));
		send_sample(6'd7, mk_sample(5102, 0, 0, 64'h100_0000_0000, 1, 0, 0, 0, 0, 0));
		send_sample(6'd7, mk_sample(5000, 3, 9, 64'h100_0000_0000, 0, 4, 2, 1, 0, 0));
		send_sample(6'd7, mk_sample(6000, 3, 9, 64'h100_0000_0000, 0, 4, 2, 1, 900, 0));
	endtask

	// mostly monotonic per-core streams, the rest noise, backward steps and near-max values
	task automatic test_random_streams(input int n_items, input int s_idle, input int r_idle,
			input bit with_pause);
		logic [CORE_W-1:0] core;
		sample_t           smp;
		cnt_t              g_inc, gn_inc;
		int                k, j, kind;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (k = 0; k < n_items; k++) begin
			if (with_pause && k == n_items / 2)
				drain_results();
			core = ($urandom_range(3) == 0) ? CORE_W'($urandom_range(CORE_SLOTS - 1))
				: CORE_W'($urandom_range(3));
			smp  = stream_cnt[core];
			kind = $urandom_range(99);
			if (kind < 70) begin
				for (j = 0; j < N_CNT; j++)
					smp[j] = smp[j] + tick_step();
				// guest time is also counted inside user and nice
				g_inc  = tick_step();
				gn_inc = tick_step();
				smp[IN_GUEST] = smp[IN_GUEST] + g_inc;
				smp[IN_USER]  = smp[IN_USER] + g_inc;
				smp[IN_GNICE] = smp[IN_GNICE] + gn_inc;
				smp[IN_NICE]  = smp[IN_NICE] + gn_inc;
			end else if (kind < 80) begin
				for (j = 0; j < N_CNT; j++)
					smp[j] = rand_cnt();
			end else if (kind < 88) begin
				j = $urandom_range(N_CNT - 1);
				smp[j] = smp[j] - tick_step();
				j = $urandom_range(N_CNT - 1);
				smp[j] = smp[j] - rand_cnt();
			end else if (kind < 95) begin
				for (j = 0; j < N_CNT; j++)
					smp[j] = {CNT_W{1'b1}} - cnt_t'($urandom_range(1000));
			end
			// otherwise the stored sample is repeated and the percentage is held
			send_sample(core, smp);
		end
	endtask

	// receiver with random back-pressure
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare every result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_usage.delta = m_tdata[639:0];
			got_usage.pct   = m_tdata[654:640];
			got_usage.fresh = m_tuser[0];
			if (usage_q.size() == 0) begin
				if (errors < MAX_REPORTS)
					$error("result with no sample pending");
				errors++;
			end else begin
				exp_usage = usage_q.pop_front();
				results_seen++;
				if (!exp_usage.fresh)
					held_seen++;
				if (exp_usage.pct == FULL_SCALE)
					full_seen++;
				for (int j = 0; j < N_CNT; j++) begin
					if (got_usage.delta[j] !== exp_usage.delta[j]) begin
						if (errors < MAX_REPORTS)
							$error("%s expected %0d got %0d", delta_name(j),
								exp_usage.delta[j], got_usage.delta[j]);
						errors++;
					end
				end
				if (got_usage.pct !== exp_usage.pct) begin
					if (errors < MAX_REPORTS)
						$error("busy_percent expected %0d got %0d",
							exp_usage.pct, got_usage.pct);
					errors++;
				end
				if (got_usage.fresh !== exp_usage.fresh) begin
					if (errors < MAX_REPORTS)
						$error("percent_fresh expected %0d got %0d",
							exp_usage.fresh, got_usage.fresh);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_cpu_core_utilization_calc_core: FAIL");
		$finish;
	end

	initial begin
		errors        = 0;
		samples_sent  = 0;
		results_seen  = 0;
		held_seen     = 0;
		full_seen     = 0;
		send_idle_pct = 14;
		recv_idle_pct = 75;
		for (int c = 0; c < CORE_SLOTS; c++) begin
			core_cnt[c]   = '0;
			core_pct[c]   = '0;
			stream_cnt[c] = '0;
		end
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_samples();
		test_saturation();
		test_backwards_and_clamp();
		test_random_streams(250, 14, 75, 1'b1);
		test_random_streams(250, 75, 14, 1'b0);
		test_random_streams(250, 0, 0, 1'b0);

		drain_results();
		repeat (40) @(posedge clk);
		if (usage_q.size() != 0) begin
			$error("%0d predicted results never arrived", usage_q.size());
			errors++;
		end

		$display("covered %0d counter samples, %0d results checked", samples_sent,
			results_seen);
		$display("held percentages %0d, full-scale shares %0d, mismatches %0d",
			held_seen, full_seen, errors);
		if (errors == 0)
			$display("tb_cpu_core_utilization_calc_core: PASS");
		else
			$display("tb_cpu_core_utilization_calc_core: FAIL");
		$finish;
	end

endmodule
